// File: sv/kcs_pkg.sv
`timescale 1ns / 1ps
package kcs_pkg;
    localparam int MaxKeys   = 16;
    localparam int IdxBits   = $clog2(MaxKeys);
    localparam int TimeBits  = 17;
    localparam int ValBits   = 32;
    localparam int DiffBits  = ValBits + 1;
    localparam int CntBits   = 5;

    localparam logic [1:0] CfgVectorMode = 2'd0;
    localparam logic [1:0] CfgKeyCount   = 2'd1;
    localparam int CfgIdxBits  = 2;
    localparam int CfgDataBits = 5;

    typedef struct packed {
        logic load;
        logic seek_init;
        logic seek_step;
        logic fetch;
        logic div_start;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic seek_done;
        logic div_done;
    } t_stat;
endpackage

// File: sv/kcs_ram.sv
`timescale 1ns / 1ps
module kcs_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/kcs_ctrl.sv
`timescale 1ns / 1ps
module kcs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_mode,
    input  kcs_pkg::t_stat i_stat,
    output kcs_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import kcs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SEEK  = 5'b00010,
        S_FETCH = 5'b00100,
        S_DIV   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_fwait, n_fwait;

    always_comb begin
        n_state = r_state;
        n_fwait = r_fwait;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_mode) begin
                        o_cmd.seek_init = 1'b1;
                        n_state = S_SEEK;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_SEEK: begin
                if (i_stat.seek_done) begin
                    o_cmd.fetch = 1'b1;
                    n_fwait = 1'b0;
                    n_state = S_FETCH;
                end else begin
                    o_cmd.seek_step = 1'b1;
                end
            end
            S_FETCH: begin
                // waits on the address reg, then the read data reg
                if (r_fwait) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_fwait = 1'b1;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fwait <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fwait <= n_fwait;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// File: sv/kcs_dp.sv
`timescale 1ns / 1ps
module kcs_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kcs_pkg::t_cmd                     i_cmd,
    output kcs_pkg::t_stat                    o_stat,
    input  logic                              i_vector_mode,
    input  logic [kcs_pkg::CntBits-1:0]       i_key_count,
    input  logic [kcs_pkg::IdxBits-1:0]       i_key_index,
    input  logic [kcs_pkg::TimeBits-1:0]      i_key_time,
    input  logic signed [kcs_pkg::ValBits-1:0] i_key_x,
    input  logic signed [kcs_pkg::ValBits-1:0] i_key_y,
    input  logic signed [kcs_pkg::ValBits-1:0] i_key_z,
    input  logic [kcs_pkg::TimeBits-1:0]      i_sample_time,
    output logic                              o_valid,
    output logic signed [kcs_pkg::ValBits-1:0] o_value_x,
    output logic signed [kcs_pkg::ValBits-1:0] o_value_y,
    output logic signed [kcs_pkg::ValBits-1:0] o_value_z,
    output logic [kcs_pkg::IdxBits-1:0]       o_segment,
    output logic                              o_status
);
    import kcs_pkg::*;

    localparam int QBits = DiffBits + TimeBits;   // product width n*|d|

    // Time table kept in flops: the seek reads it at two cursor-chosen places
    // per cycle, so it stays small (16 x 17).
    logic [TimeBits-1:0] r_times [MaxKeys];
    logic [IdxBits-1:0]  r_cursor;
    logic [TimeBits-1:0] r_t;
    logic [IdxBits-1:0]  r_last;
    logic [IdxBits-1:0]  w_raddr;
    logic [ValBits-1:0]  w_x0, w_x1, w_y0, w_y1, w_z0, w_z1;

    // clamp key count to 2..MaxKeys
    logic [CntBits-1:0] w_kc;
    always_comb begin
        w_kc = i_key_count;
        if (w_kc < CntBits'(2)) w_kc = CntBits'(2);
        if (w_kc > CntBits'(MaxKeys)) w_kc = CntBits'(MaxKeys);
    end

    logic [IdxBits-1:0] w_nxt;
    assign w_nxt = r_cursor + 1'b1;
    assign o_stat.seek_done = !((r_cursor < r_last) && (r_times[w_nxt] < r_t));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_times[i_key_index] <= i_key_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
        end else if (i_cmd.load) begin
            r_cursor <= '0;
        end else if (i_cmd.seek_init) begin
            // stale cursor, or current key beyond sample time: rewind
            if (r_cursor > IdxBits'(w_kc - CntBits'(2)) || r_times[r_cursor] > i_sample_time)
                r_cursor <= '0;
        end else if (i_cmd.seek_step) begin
            r_cursor <= w_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seek_init) begin
            r_t    <= i_sample_time;
            r_last <= IdxBits'(w_kc - CntBits'(2));
        end
    end

    // value memories: port A reads v0, port B reads v1, via second copy
    assign w_raddr = r_cursor;

    kcs_ram #(.Width(ValBits), .Depth(MaxKeys)) u_x0 (.i_clk, .i_we(i_cmd.load),
        .i_waddr(i_key_index), .i_wdata(i_key_x), .i_raddr(w_raddr), .o_rdata(w_x0));
    kcs_ram #(.Width(ValBits), .Depth(MaxKeys)) u_x1 (.i_clk, .i_we(i_cmd.load),
        .i_waddr(i_key_index), .i_wdata(i_key_x), .i_raddr(w_nxt), .o_rdata(w_x1));
    kcs_ram #(.Width(ValBits), .Depth(MaxKeys)) u_y0 (.i_clk, .i_we(i_cmd.load),
        .i_waddr(i_key_index), .i_wdata(i_key_y), .i_raddr(w_raddr), .o_rdata(w_y0));
    kcs_ram #(.Width(ValBits), .Depth(MaxKeys)) u_y1 (.i_clk, .i_we(i_cmd.load),
        .i_waddr(i_key_index), .i_wdata(i_key_y), .i_raddr(w_nxt), .o_rdata(w_y1));
    kcs_ram #(.Width(ValBits), .Depth(MaxKeys)) u_z0 (.i_clk, .i_we(i_cmd.load),
        .i_waddr(i_key_index), .i_wdata(i_key_z), .i_raddr(w_raddr), .o_rdata(w_z0));
    kcs_ram #(.Width(ValBits), .Depth(MaxKeys)) u_z1 (.i_clk, .i_we(i_cmd.load),
        .i_waddr(i_key_index), .i_wdata(i_key_z), .i_raddr(w_nxt), .o_rdata(w_z1));

    // segment times and flag, registered on fetch
    logic [TimeBits-1:0] r_num, r_den;
    logic                r_flag;
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_num  <= r_t - r_times[r_cursor];
            r_den  <= r_times[w_nxt] - r_times[r_cursor];
            r_flag <= (r_t < r_times[r_cursor]) || (r_t > r_times[w_nxt])
                   || (r_times[w_nxt] == r_times[r_cursor]);
        end
    end

    // per component: |d| * n through the shared multiplier, then restoring divide
    logic signed [ValBits-1:0] r_v0 [3];
    logic                      r_neg [3];
    logic [QBits-1:0]          r_quo [3];
    logic [TimeBits:0]         r_rem [3];
    logic [1:0]                r_ph;
    logic [1:0]                r_mc;
    logic [$clog2(QBits+1)-1:0] r_bc;
    logic                      r_dd;
    logic [ValBits-1:0]        w_v0 [3];
    logic [ValBits-1:0]        w_v1 [3];

    assign w_v0[0] = w_x0; assign w_v0[1] = w_y0; assign w_v0[2] = w_z0;
    assign w_v1[0] = w_x1; assign w_v1[1] = w_y1; assign w_v1[2] = w_z1;

    logic signed [DiffBits-1:0] w_d   [3];
    logic [DiffBits-1:0]        w_mag [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_d[k]   = DiffBits'(signed'(w_v1[k])) - DiffBits'(signed'(w_v0[k]));
            w_mag[k] = w_d[k][DiffBits-1] ? DiffBits'(-w_d[k]) : DiffBits'(w_d[k]);
        end
    end

    logic [QBits-1:0]  w_prod;
    logic [1:0]        w_mi;
    assign w_mi   = r_mc;
    assign w_prod = QBits'(r_quo[w_mi][DiffBits-1:0]) * QBits'(r_num);

    logic [TimeBits:0] w_trial [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_trial[k] = {r_rem[k][TimeBits-1:0], r_quo[k][QBits-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= 2'd0;
            r_dd <= 1'b0;
            r_mc <= 2'd0;
            r_bc <= '0;
        end else begin
            r_dd <= 1'b0;
            if (i_cmd.div_start) begin
                for (int k = 0; k < 3; k++) begin
                    r_v0[k]  <= signed'(w_v0[k]);
                    r_neg[k] <= w_d[k][DiffBits-1];
                    r_quo[k] <= QBits'(w_mag[k]);
                    r_rem[k] <= '0;
                end
                r_mc <= 2'd0;
                r_ph <= r_flag ? 2'd3 : 2'd1;
                if (r_flag) r_dd <= 1'b1;
            end else if (r_ph == 2'd1) begin
                r_quo[w_mi] <= w_prod;
                if (r_mc == 2'd2) begin
                    r_ph <= 2'd2;
                    r_bc <= '0;
                end
                r_mc <= r_mc + 2'd1;
            end else if (r_ph == 2'd2) begin
                for (int k = 0; k < 3; k++) begin
                    if (w_trial[k] >= {1'b0, r_den}) begin
                        r_rem[k] <= w_trial[k] - {1'b0, r_den};
                        r_quo[k] <= {r_quo[k][QBits-2:0], 1'b1};
                    end else begin
                        r_rem[k] <= w_trial[k];
                        r_quo[k] <= {r_quo[k][QBits-2:0], 1'b0};
                    end
                end
                r_bc <= r_bc + 1'b1;
                if (r_bc == $bits(r_bc)'(QBits - 1)) begin
                    r_ph <= 2'd3;
                    r_dd <= 1'b1;
                end
            end else if (r_ph == 2'd3 && i_cmd.emit) begin
                r_ph <= 2'd0;
            end
        end
    end
    assign o_stat.div_done = r_dd;

    logic signed [ValBits-1:0] w_res [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_flag)
                w_res[k] = r_v0[k];
            else if (r_neg[k])
                w_res[k] = r_v0[k] - signed'(ValBits'(r_quo[k]));
            else
                w_res[k] = r_v0[k] + signed'(ValBits'(r_quo[k]));
        end
    end

    logic                      r_valid;
    logic signed [ValBits-1:0] r_ox, r_oy, r_oz;
    logic [IdxBits-1:0]        r_oseg;
    logic                      r_ost;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= i_cmd.emit;
        if (i_cmd.emit) begin
            r_ox   <= w_res[0];
            r_oy   <= i_vector_mode ? w_res[1] : '0;
            r_oz   <= i_vector_mode ? w_res[2] : '0;
            r_oseg <= r_cursor;
            r_ost  <= r_flag;
        end
    end

    assign o_valid   = r_valid;
    assign o_value_x = r_ox;
    assign o_value_y = r_oy;
    assign o_value_z = r_oz;
    assign o_segment = r_oseg;
    assign o_status  = r_ost;
endmodule

// File: sv/keyframe_curve_sampler_core.sv
`timescale 1ns / 1ps
// channel   | handshake          | payload
// ----------+--------------------+------------------------------------------
// item in   | start / busy       | i_mode i_key_index i_key_time i_key_x/y/z
//           |                    | i_sample_time
// result    | o_done (1 cycle)   | o_value_x/y/z o_segment o_status
// config    | i_cfg_we           | i_cfg_index i_cfg_data
// A load item gives no result and does not raise busy.
// A sample item holds busy through the seek (one cursor step at a time, up to
// 14 steps), the fetch, the shared multiplier and a 50-step restoring divider,
// and emit. o_done strobes in the same cycle that busy drops.
// A degenerate or outside segment skips the arithmetic.
// The result strobe cannot be stalled.
// Reset is synchronous; the key table is undefined until loaded.
module keyframe_curve_sampler_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kcs_pkg::CfgIdxBits-1:0]      i_cfg_index,
    input  logic [kcs_pkg::CfgDataBits-1:0]     i_cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_mode,
    input  logic [kcs_pkg::IdxBits-1:0]         i_key_index,
    input  logic [kcs_pkg::TimeBits-1:0]        i_key_time,
    input  logic signed [kcs_pkg::ValBits-1:0]  i_key_x,
    input  logic signed [kcs_pkg::ValBits-1:0]  i_key_y,
    input  logic signed [kcs_pkg::ValBits-1:0]  i_key_z,
    input  logic [kcs_pkg::TimeBits-1:0]        i_sample_time,
    output logic                                o_done,
    output logic signed [kcs_pkg::ValBits-1:0]  o_value_x,
    output logic signed [kcs_pkg::ValBits-1:0]  o_value_y,
    output logic signed [kcs_pkg::ValBits-1:0]  o_value_z,
    output logic [kcs_pkg::IdxBits-1:0]         o_segment,
    output logic                                o_status
);
    import kcs_pkg::*;

    logic               r_vector_mode;
    logic [CntBits-1:0] r_key_count;
    t_cmd               w_cmd;
    t_stat              w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_mode <= 1'b0;
            r_key_count   <= CntBits'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgVectorMode: r_vector_mode <= i_cfg_data[0];
                CfgKeyCount:   r_key_count   <= i_cfg_data[CntBits-1:0];
                default: ;
            endcase
        end
    end

    kcs_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_mode,
        .i_stat(w_stat), .o_cmd(w_cmd), .o_busy(busy)
    );

    kcs_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_stat(w_stat),
        .i_vector_mode(r_vector_mode), .i_key_count(r_key_count),
        .i_key_index, .i_key_time, .i_key_x, .i_key_y, .i_key_z, .i_sample_time,
        .o_valid(o_done), .o_value_x, .o_value_y, .o_value_z, .o_segment, .o_status
    );
endmodule

// File: dv/keyframe_curve_sampler_core_test.sv
`timescale 1ns / 1ps
module keyframe_curve_sampler_core_test;
    import kcs_pkg::*;

    localparam logic ModeLoad   = 1'b0;
    localparam logic ModeSample = 1'b1;
    localparam int   RandItems  = 1650;
    localparam int   CycleLimit = 1000000;
    localparam int   SettleCycles = 100;

    typedef enum logic [1:0] {RowLoad, RowSample, RowCfg} t_row_kind;

    typedef struct {
        logic signed [ValBits-1:0] x;
        logic signed [ValBits-1:0] y;
        logic signed [ValBits-1:0] z;
        logic [IdxBits-1:0]        seg;
        logic                      status;
    } t_point;

    typedef struct {
        t_row_kind           kind;
        logic [IdxBits-1:0]  idx;
        logic [CfgDataBits-1:0] cfg;
        logic [TimeBits-1:0] tm;
        logic [ValBits-1:0]  x, y, z;
        bit                  typed;
        t_point              want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxBits-1:0] i_cfg_index;
    logic [CfgDataBits-1:0] i_cfg_data;
    logic start;
    logic busy;
    logic i_mode;
    logic [IdxBits-1:0] i_key_index;
    logic [TimeBits-1:0] i_key_time;
    logic signed [ValBits-1:0] i_key_x, i_key_y, i_key_z;
    logic [TimeBits-1:0] i_sample_time;
    logic o_done;
    logic signed [ValBits-1:0] o_value_x, o_value_y, o_value_z;
    logic [IdxBits-1:0] o_segment;
    logic o_status;

    keyframe_curve_sampler_core dut (.*);

    // shadow of the key table and control state
    logic [TimeBits-1:0]       key_t [MaxKeys];
    logic signed [ValBits-1:0] key_x [MaxKeys];
    logic signed [ValBits-1:0] key_y [MaxKeys];
    logic signed [ValBits-1:0] key_z [MaxKeys];
    int unsigned seg_cursor;
    bit          vec_mode;
    int unsigned keys_used;

    t_point pending_points[$];
    bit     failed;
    int     cycles;
    bit     no_gaps;
    int     items_sent;
    t_row   rows[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("keyframe_curve_sampler_core regression: fail");
            $finish;
        end
    end

    function automatic longint lerp(longint v0, longint v1, longint n, longint den);
        longint d, mag, q;
        d   = v1 - v0;
        mag = (d < 0) ? -d : d;
        q   = (mag / den) * n + ((mag % den) * n) / den;
        return (d < 0) ? v0 - q : v0 + q;
    endfunction

    function automatic t_point sample_curve(logic [TimeBits-1:0] ts);
        t_point p;
        int unsigned kc, last_seg, c, t0, t1;
        bit flag;
        kc = keys_used;
        if (kc < 2) kc = 2;
        if (kc > MaxKeys) kc = MaxKeys;
        last_seg = kc - 2;
        if (seg_cursor > last_seg) seg_cursor = 0;
        if (key_t[seg_cursor] > ts) seg_cursor = 0;
        while (seg_cursor < last_seg && key_t[seg_cursor + 1] < ts)
            seg_cursor++;
        c  = seg_cursor;
        t0 = key_t[c];
        t1 = key_t[c + 1];
        flag = (ts < t0) || (ts > t1) || (t1 == t0);
        if (flag) begin
            p.x = key_x[c];
            p.y = key_y[c];
            p.z = key_z[c];
        end else begin
            p.x = ValBits'(lerp(key_x[c], key_x[c + 1], ts - t0, t1 - t0));
            p.y = ValBits'(lerp(key_y[c], key_y[c + 1], ts - t0, t1 - t0));
            p.z = ValBits'(lerp(key_z[c], key_z[c + 1], ts - t0, t1 - t0));
        end
        if (!vec_mode) begin
            p.y = '0;
            p.z = '0;
        end
        p.seg    = IdxBits'(c);
        p.status = flag;
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_point w;
        if (i_rst_n && o_done) begin
            if (pending_points.size() == 0) begin
                $error("result with no sample item outstanding");
                failed = 1'b1;
            end else begin
                w = pending_points.pop_front();
                if (o_value_x !== w.x) begin
                    $error("value_x: expected %0d, got %0d", w.x, o_value_x);
                    failed = 1'b1;
                end
                if (o_value_y !== w.y) begin
                    $error("value_y: expected %0d, got %0d", w.y, o_value_y);
                    failed = 1'b1;
                end
                if (o_value_z !== w.z) begin
                    $error("value_z: expected %0d, got %0d", w.z, o_value_z);
                    failed = 1'b1;
                end
                if (o_segment !== w.seg) begin
                    $error("segment: expected %0d, got %0d", w.seg, o_segment);
                    failed = 1'b1;
                end
                if (o_status !== w.status) begin
                    $error("status: expected %0d, got %0d", w.status, o_status);
                    failed = 1'b1;
                end
            end
        end
    end

    // called on a rising edge; returns on the rising edge of the next drive slot
    task automatic send_item(logic mode, logic [IdxBits-1:0] idx, logic [TimeBits-1:0] tm,
                             logic [ValBits-1:0] x, logic [ValBits-1:0] y,
                             logic [ValBits-1:0] z, logic [TimeBits-1:0] ts,
                             bit typed, t_point want);
        t_point p;
        int gap;
        start         <= 1'b1;
        i_mode        <= mode;
        i_key_index   <= idx;
        i_key_time    <= tm;
        i_key_x       <= x;
        i_key_y       <= y;
        i_key_z       <= z;
        i_sample_time <= ts;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        items_sent++;
        if (mode == ModeLoad) begin
            key_t[idx] = tm;
            key_x[idx] = x;
            key_y[idx] = y;
            key_z[idx] = z;
            seg_cursor = 0;
        end else begin
            p = sample_curve(ts);
            pending_points.push_back(typed ? want : p);
        end
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_points.size() != 0 || busy) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CfgVectorMode) vec_mode = val[0];
        else if (idx == CfgKeyCount) keys_used = val;
        @(posedge i_clk);
    endtask

    function automatic logic [ValBits-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
            3: return $urandom_range(0, 200) - 100;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_row mk(t_row_kind k, logic [IdxBits-1:0] idx, logic [TimeBits-1:0] tm,
                                logic [ValBits-1:0] x, logic [ValBits-1:0] y,
                                logic [ValBits-1:0] z, bit typed = 0, t_point want = '{default: 0});
        t_row r;
        r.kind = k; r.idx = idx; r.tm = tm; r.x = x; r.y = y; r.z = z;
        r.cfg = x[CfgDataBits-1:0];
        r.typed = typed; r.want = want;
        return r;
    endfunction

    initial begin
        t_point none;
        int unsigned kc, nk, ns, times[$];
        logic [TimeBits-1:0] ts;
        none = '{default: 0};
        cycles = 0; failed = 0; items_sent = 0; no_gaps = 0;
        seg_cursor = 0; vec_mode = 0; keys_used = 2;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        start = 1'b0; i_mode = ModeLoad; i_key_index = '0; i_key_time = '0;
        i_key_x = '0; i_key_y = '0; i_key_z = '0; i_sample_time = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every slot so no sample ever reads an unwritten key
        for (int i = 0; i < MaxKeys; i++)
            send_item(ModeLoad, IdxBits'(i), TimeBits'(i * 4096), rand_value(), rand_value(),
                      rand_value(), 0, 0, none);
        wait_idle();

        rows.push_back(mk(RowCfg, CfgVectorMode, 0, 1, 0, 0));
        rows.push_back(mk(RowCfg, CfgKeyCount, 0, 4, 0, 0));
        rows.push_back(mk(RowLoad, 0, 0, 32'h8000_0000, 0, 32'h7fff_ffff));
        rows.push_back(mk(RowLoad, 1, 17'h4000, 32'h7fff_ffff, -65536, 0));
        rows.push_back(mk(RowLoad, 2, 17'h4000, 100, 200, 300));
        rows.push_back(mk(RowLoad, 3, 17'h10000, -1, 1, 0));
        rows.push_back(mk(RowSample, 0, 0, 0, 0, 0, 1,
                          '{32'h8000_0000, 0, 32'h7fff_ffff, 0, 0}));
        rows.push_back(mk(RowSample, 0, 17'h4000, 0, 0, 0, 1,
                          '{32'h7fff_ffff, -65536, 0, 0, 0}));
        rows.push_back(mk(RowSample, 0, 17'h2000, 0, 0, 0));
        rows.push_back(mk(RowSample, 0, 17'h8000, 0, 0, 0));
        rows.push_back(mk(RowSample, 0, 17'h10000, 0, 0, 0, 1, '{-1, 1, 0, 2, 0}));
        // beyond 1.0: outside the last segment
        rows.push_back(mk(RowSample, 0, 17'h1ffff, 0, 0, 0, 1, '{100, 200, 300, 2, 1}));
        // rewind from segment 2
        rows.push_back(mk(RowSample, 0, 17'h1000, 0, 0, 0));
        rows.push_back(mk(RowSample, 0, 17'h8000, 0, 0, 0));
        // shrink the count: cursor 2 is stale
        rows.push_back(mk(RowCfg, CfgKeyCount, 0, 3, 0, 0));
        rows.push_back(mk(RowSample, 0, 17'h4000, 0, 0, 0, 1,
                          '{32'h7fff_ffff, -65536, 0, 0, 0}));
        // zero-length segment
        rows.push_back(mk(RowCfg, CfgKeyCount, 0, 4, 0, 0));
        rows.push_back(mk(RowLoad, 3, 17'h4000, 5, 6, 7));
        rows.push_back(mk(RowSample, 0, 17'h5000, 0, 0, 0, 1, '{100, 200, 300, 2, 1}));
        rows.push_back(mk(RowCfg, CfgVectorMode, 0, 0, 0, 0));
        rows.push_back(mk(RowCfg, CfgKeyCount, 0, 0, 0, 0));
        rows.push_back(mk(RowSample, 0, 17'h3000, 0, 0, 0));
        rows.push_back(mk(RowCfg, CfgKeyCount, 0, 31, 0, 0));
        rows.push_back(mk(RowLoad, 15, 17'h1ffff, 32'h7fff_ffff, 32'h8000_0000, 1));
        rows.push_back(mk(RowSample, 0, 17'h1ffff, 0, 0, 0));

        foreach (rows[i]) begin
            if (rows[i].kind == RowCfg) begin
                wait_idle();
                write_cfg(rows[i].idx[CfgIdxBits-1:0], rows[i].cfg);
            end else if (rows[i].kind == RowLoad) begin
                send_item(ModeLoad, rows[i].idx, rows[i].tm, rows[i].x, rows[i].y, rows[i].z,
                          $urandom, 0, none);
            end else begin
                send_item(ModeSample, $urandom, $urandom, $urandom, $urandom, $urandom,
                          rows[i].tm, rows[i].typed, rows[i].want);
            end
        end

        while (items_sent < RandItems) begin
            wait_idle();
            no_gaps = ($urandom_range(0, 3) == 0);
            write_cfg(CfgVectorMode, CfgDataBits'($urandom));
            case ($urandom_range(0, 9))
                0: kc = 0;
                1: kc = 31;
                2: kc = $urandom_range(17, 31);
                3: kc = 16;
                default: kc = $urandom_range(2, 8);
            endcase
            write_cfg(CfgKeyCount, CfgDataBits'(kc));
            nk = (kc < 2) ? 2 : (kc > MaxKeys ? MaxKeys : kc);
            if ($urandom_range(0, 6) == 0) begin
                // noise: stray loads and arbitrary samples
                repeat ($urandom_range(5, 20)) begin
                    if ($urandom_range(0, 1))
                        send_item(ModeLoad, $urandom, $urandom, rand_value(), rand_value(),
                                  rand_value(), $urandom, 0, none);
                    else
                        send_item(ModeSample, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, 0, none);
                end
            end else begin
                times.delete();
                for (int i = 0; i < nk; i++) begin
                    case ($urandom_range(0, 9))
                        0: times.push_back(17'h1ffff);
                        1: times.push_back(times.size() ? times[$] : 0);
                        default: times.push_back($urandom_range(0, 65536));
                    endcase
                end
                times.sort();
                if ($urandom_range(0, 3) != 0) begin
                    times[0] = 0;
                    times[nk - 1] = 65536;
                    times.sort();
                end
                for (int i = 0; i < nk; i++)
                    send_item(ModeLoad, IdxBits'(i), TimeBits'(times[i]), rand_value(),
                              rand_value(), rand_value(), $urandom, 0, none);
                ns = $urandom_range(8, 40);
                repeat (ns) begin
                    case ($urandom_range(0, 5))
                        0: ts = TimeBits'(times[$urandom_range(0, nk - 1)]);
                        1: ts = TimeBits'($urandom);
                        2: ts = $urandom_range(0, 1) ? TimeBits'(0) : TimeBits'(65536);
                        default: ts = TimeBits'($urandom_range(0, 65536));
                    endcase
                    send_item(ModeSample, $urandom, $urandom, $urandom, $urandom, $urandom,
                              ts, 0, none);
                end
            end
        end

        wait_idle();
        if (!failed)
            $display("keyframe_curve_sampler_core regression: pass");
        else
            $display("keyframe_curve_sampler_core regression: fail");
        $finish;
    end
endmodule
